FILE: design/gts_pkg.sv
// Package for the GPT table scanner: constants, result types, CRC helper.
// No dependencies.
package gts_pkg;

  localparam int unsigned MaxFound    = 16;
  localparam int unsigned FoundW      = $clog2(MaxFound + 1);
  localparam int unsigned SlotW       = (MaxFound > 1) ? $clog2(MaxFound) : 1;
  localparam int unsigned SectorBytes = 512;
  localparam int unsigned HdrMinLen   = 92;
  localparam int unsigned ArrayMax    = 128 * 1024;
  localparam int unsigned EntryMin    = 128;
  localparam logic [31:0] CrcPoly     = 32'hEDB88320;
  localparam logic [63:0] Signature   = 64'h5452415020494645; // "EFI PART" LE

  localparam logic [1:0] CfgMedium  = 2'd0;
  localparam logic [1:0] CfgHdrLba  = 2'd1;
  localparam logic [1:0] CfgGuidLo  = 2'd2;
  localparam logic [1:0] CfgGuidHi  = 2'd3;

  localparam logic [1:0] VerdRead    = 2'd0;
  localparam logic [1:0] VerdAbsent  = 2'd1;
  localparam logic [1:0] VerdDamaged = 2'd2;

  // command from front to back end
  typedef enum logic [1:0] {
    CmdRecord  = 2'd0,
    CmdVerdict = 2'd1,
    CmdFlush   = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [63:0] start;
    logic [63:0] count;
    logic [7:0]  index;
    logic [1:0]  verdict;
  } job_t;

  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) r = (r >> 1) ^ (CrcPoly & {32{r[0]}});
    return r;
  endfunction

endpackage

FILE: design/gts_front.sv
// Front end: parses header and entry array bytes, checks CRCs and geometry,
// and issues record, verdict and flush jobs. Depends on gts_pkg.
module gts_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               start_req_i,
  input  logic [63:0]        medium_q_i,
  input  logic [63:0]        hdr_lba_q_i,
  input  logic [127:0]       guid_q_i,
  output logic               job_valid_o,
  output gts_pkg::job_t      job_o,
  input  logic               job_full_i
);
  import gts_pkg::*;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StHdr   = 4'b0010,
    StCheck = 4'b0100,
    StArr   = 4'b1000
  } state_e;

  state_e      state_q, state_d;
  logic [17:0] pos_q, pos_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] hlen_q, hlen_d, ents_q, ents_d, esz_q, esz_d;
  logic [31:0] hcrc_q, hcrc_d, acrc_q, acrc_d;
  logic [63:0] alba_q, alba_d, own_q, own_d;
  logic        nosig_q, nosig_d, match_q, match_d;
  logic [63:0] first_q, first_d, last_q, last_d;
  logic [31:0] enum_q, enum_d;
  logic [17:0] eoff_q, eoff_d;
  logic [FoundW-1:0] tot_q, tot_d;
  // derived geometry, registered during check
  logic [17:0] abytes_q, abytes_d;
  logic [17:0] aend_q, aend_d;
  logic [2:0]  chk_q, chk_d;
  logic        bad_q, bad_d;
  logic [63:0] prod_q, prod_d;

  logic acc;
  assign acc = valid_i && !stall_o;

  // stall only while a job cannot be queued or header check runs
  assign stall_o = job_full_i || (state_q == StCheck);

  always_comb begin
    logic [17:0] p;
    logic [17:0] o;
    logic [7:0]  b;
    logic [7:0]  want;
    logic [63:0] lastn;
    state_d = state_q; pos_d = pos_q; crc_d = crc_q; hlen_d = hlen_q;
    ents_d = ents_q; esz_d = esz_q; hcrc_d = hcrc_q; acrc_d = acrc_q;
    alba_d = alba_q; own_d = own_q; nosig_d = nosig_q; match_d = match_q;
    first_d = first_q; last_d = last_q; enum_d = enum_q; eoff_d = eoff_q;
    tot_d = tot_q; abytes_d = abytes_q; aend_d = aend_q; chk_d = chk_q;
    bad_d = bad_q; prod_d = prod_q;
    job_valid_o = 1'b0;
    job_o = '{cmd: CmdVerdict, start: '0, count: '0, index: '0, verdict: VerdRead};
    b = data_byte_i;
    p = pos_q;
    o = eoff_q;
    want = '0;
    lastn = '0;
    if (state_q == StCheck) begin
      // one check a cycle while the job queue is not full
      unique case (chk_q)
        3'd0: begin
          bad_d = (hlen_q < HdrMinLen) || (hlen_q > SectorBytes) ||
                  ((crc_q ^ 32'hFFFFFFFF) != hcrc_q) || (own_q != hdr_lba_q_i) ||
                  (esz_q < EntryMin) || (ents_q == 0) || (esz_q > ArrayMax);
          prod_d = {32'd0, ents_q} * {32'd0, esz_q};
          chk_d = 3'd1;
        end
        3'd1: begin
          if (prod_q > ArrayMax) bad_d = 1'b1;
          abytes_d = prod_q[17:0];
          aend_d = ((prod_q[17:0] + 18'(SectorBytes - 1)) >> 9) << 9;
          chk_d = 3'd2;
        end
        3'd2: begin
          if (medium_q_i != 0 && (alba_q >= medium_q_i ||
              {46'd0, aend_q >> 9} > medium_q_i - alba_q)) bad_d = 1'b1;
          chk_d = 3'd3;
        end
        default: begin
          if (nosig_q || bad_d) begin
            job_valid_o = 1'b1;
            job_o.verdict = nosig_q ? VerdAbsent : VerdDamaged;
            state_d = StIdle;
          end else begin
            state_d = StArr;
            pos_d = '0; crc_d = '1; enum_d = '0; eoff_d = '0; tot_d = '0;
          end
        end
      endcase
    end else if (acc && (start_req_i || state_q != StIdle)) begin
      if (start_req_i) begin
        state_d = StHdr; p = '0; crc_d = '1; hlen_d = '0; ents_d = '0; esz_d = '0;
        hcrc_d = '0; acrc_d = '0; alba_d = '0; own_d = '0; nosig_d = 1'b0;
        tot_d = '0;
        job_valid_o = 1'b1; job_o.cmd = CmdFlush; // drop stale records
      end
      if (start_req_i || state_q == StHdr) begin
        if (p < 8 && b != Signature[p[2:0]*8 +: 8]) nosig_d = 1'b1;
        if (p >= 18'h0C && p < 18'h10) hlen_d[p[1:0]*8 +: 8] = b;
        if (p >= 18'h10 && p < 18'h14) hcrc_d[p[1:0]*8 +: 8] = b;
        if (p >= 18'h18 && p < 18'h20) own_d[p[2:0]*8 +: 8] = b;
        if (p >= 18'h48 && p < 18'h50) alba_d[p[2:0]*8 +: 8] = b;
        if (p >= 18'h50 && p < 18'h54) ents_d[p[1:0]*8 +: 8] = b;
        if (p >= 18'h54 && p < 18'h58) esz_d[p[1:0]*8 +: 8] = b;
        if (p >= 18'h58 && p < 18'h5C) acrc_d[p[1:0]*8 +: 8] = b;
        if (p < 16 || {14'd0, p} < hlen_d)
          crc_d = crc_byte(crc_d, (p >= 18'h10 && p < 18'h14) ? 8'd0 : b);
        if (p < SectorBytes - 1) pos_d = p + 18'd1;
        else begin
          state_d = StCheck; chk_d = 3'd0; bad_d = 1'b0;
        end
      end else begin
        if (p < abytes_q) begin
          crc_d = crc_byte(crc_q, b);
          if (o == 0) begin
            match_d = 1'b1; first_d = '0; last_d = '0;
          end
          if (o < 16) begin
            want = guid_q_i[o[3:0]*8 +: 8];
            if (want != b) match_d = 1'b0;
          end
          if (o >= 18'h20 && o < 18'h28) first_d[o[2:0]*8 +: 8] = b;
          if (o >= 18'h28 && o < 18'h30) last_d[o[2:0]*8 +: 8] = b;
          lastn = last_d;
          if (o == 18'h2F && match_d && lastn >= first_d &&
              (medium_q_i == 0 || lastn < medium_q_i) && tot_q < FoundW'(MaxFound)) begin
            job_valid_o = 1'b1;
            job_o.cmd = CmdRecord;
            job_o.start = first_d;
            job_o.count = lastn - first_d + 64'd1;
            job_o.index = enum_q[7:0];
            tot_d = tot_q + FoundW'(1);
          end
          if ({14'd0, o} + 32'd1 >= esz_q) begin
            eoff_d = '0; enum_d = enum_q + 32'd1;
          end else eoff_d = o + 18'd1;
        end
        if (p + 18'd1 < aend_q) pos_d = p + 18'd1;
        else begin
          state_d = StIdle;
          job_valid_o = 1'b1;
          job_o.cmd = CmdVerdict;
          job_o.verdict = ((crc_d ^ 32'hFFFFFFFF) != acrc_q) ? VerdDamaged : VerdRead;
        end
      end
    end
    // StCheck may need the queue too
    if (state_q == StCheck && job_full_i) begin
      job_valid_o = 1'b0;
      state_d = state_q; chk_d = chk_q; bad_d = bad_q;
      pos_d = pos_q; crc_d = crc_q; enum_d = enum_q; eoff_d = eoff_q; tot_d = tot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; pos_q <= '0; crc_q <= '1; tot_q <= '0; chk_q <= '0;
      nosig_q <= 1'b0; match_q <= 1'b0; eoff_q <= '0; enum_q <= '0;
      hlen_q <= '0; ents_q <= '0; esz_q <= '0; abytes_q <= '0; aend_q <= '0;
      bad_q <= 1'b0;
    end else begin
      state_q <= state_d; pos_q <= pos_d; crc_q <= crc_d; tot_q <= tot_d;
      chk_q <= chk_d; nosig_q <= nosig_d; match_q <= match_d; eoff_q <= eoff_d;
      enum_q <= enum_d; hlen_q <= hlen_d; ents_q <= ents_d; esz_q <= esz_d;
      abytes_q <= abytes_d; aend_q <= aend_d; bad_q <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hcrc_q <= hcrc_d; acrc_q <= acrc_d; alba_q <= alba_d; own_q <= own_d;
    first_q <= first_d; last_q <= last_d; prod_q <= prod_d;
  end

`ifndef ASSERT_OFF
  a_no_job_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_full_i |-> !job_valid_o) else $error("job issued into full queue");
  a_tot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tot_q <= FoundW'(MaxFound)) else $error("record count overflow");
  a_check_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCheck && chk_q == 3'd3 && !job_full_i) |=> state_q != StCheck)
    else $error("header check stuck");
`endif

endmodule

FILE: design/gts_back.sv
// Back end: holds records until the verdict, then emits them (a damaged or
// absent verdict drops them) and the verdict through an output register. Depends on gts_pkg.
module gts_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  gts_pkg::job_t      job_i,
  output logic               job_full_o,
  output logic               valid_o,
  input  logic               stall_i,
  output logic               kind_o,
  output logic [63:0]        first_sector_o,
  output logic [63:0]        sector_count_o,
  output logic [7:0]         entry_index_o,
  output logic [1:0]         verdict_o,
  output logic               last_o
);
  import gts_pkg::*;

  logic [63:0] st_mem [MaxFound];
  logic [63:0] ct_mem [MaxFound];
  logic [7:0]  ix_mem [MaxFound];
  logic [FoundW-1:0] wr_q, rd_q;
  logic        drain_q;   // emitting stored records then verdict
  logic [1:0]  dverd_q;
  logic        ov_q;
  logic        out_free, emit;

  assign out_free = !ov_q || !stall_i;
  assign job_full_o = drain_q;
  assign valid_o = ov_q;
  assign emit = drain_q && out_free;

  always_ff @(posedge clk_i) begin
    if (job_valid_i && job_i.cmd == CmdRecord) begin
      st_mem[wr_q[SlotW-1:0]] <= job_i.start;
      ct_mem[wr_q[SlotW-1:0]] <= job_i.count;
      ix_mem[wr_q[SlotW-1:0]] <= job_i.index;
    end
    if (emit) begin
      if (rd_q < wr_q) begin
        kind_o <= 1'b0; first_sector_o <= st_mem[rd_q[SlotW-1:0]];
        sector_count_o <= ct_mem[rd_q[SlotW-1:0]]; entry_index_o <= ix_mem[rd_q[SlotW-1:0]];
        verdict_o <= VerdRead; last_o <= 1'b0;
      end else begin
        kind_o <= 1'b1; first_sector_o <= '0; sector_count_o <= '0;
        entry_index_o <= '0; verdict_o <= dverd_q; last_o <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; drain_q <= 1'b0; dverd_q <= VerdRead; ov_q <= 1'b0;
    end else begin
      if (ov_q && !stall_i) ov_q <= 1'b0;
      if (emit) begin
        ov_q <= 1'b1;
        if (rd_q < wr_q) rd_q <= rd_q + FoundW'(1);
        else begin
          drain_q <= 1'b0; wr_q <= '0; rd_q <= '0;
        end
      end else if (job_valid_i) begin
        unique case (job_i.cmd)
          CmdRecord: wr_q <= wr_q + FoundW'(1);
          CmdFlush:  wr_q <= '0;
          CmdVerdict: begin
            drain_q <= 1'b1; rd_q <= '0; dverd_q <= job_i.verdict;
            if (job_i.verdict != VerdRead) wr_q <= '0;
          end
          default: ;
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  a_rd_le_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_q <= wr_q) else $error("read past stored records");
  a_no_job_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> !job_valid_i) else $error("job during drain");
  a_last_ends_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && rd_q == wr_q) |=> (last_o && !drain_q)) else $error("verdict lost");
`endif

endmodule

FILE: design/gpt_table_scanner.sv
// GPT table scanner: one byte per cycle in while not stalled; header checks
// run after the last header byte, stalling input. A header failure verdict
// reaches the output through the drain flag and the output register. Records
// and verdict leave one a cycle through an output register while the output
// is not stalled; after the final array byte the drain flag is set, then the
// first result is registered. While the results drain, input is stalled.
// Reset (asynchronous, active low) returns to idle with defaults: header sector 1.
module gpt_table_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_req_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic        kind_o,
  output logic [63:0] first_sector_o,
  output logic [63:0] sector_count_o,
  output logic [7:0]  entry_index_o,
  output logic [1:0]  verdict_o,
  output logic        last_o
);
  import gts_pkg::*;

  logic [63:0] medium_q, hdr_lba_q, guid_lo_q, guid_hi_q;
  logic        job_valid, job_full;
  job_t        job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      medium_q <= '0; hdr_lba_q <= 64'd1; guid_lo_q <= '0; guid_hi_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMedium: medium_q  <= cfg_data_i;
        CfgHdrLba: hdr_lba_q <= cfg_data_i;
        CfgGuidLo: guid_lo_q <= cfg_data_i;
        CfgGuidHi: guid_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gts_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .data_byte_i, .start_req_i,
    .medium_q_i(medium_q), .hdr_lba_q_i(hdr_lba_q),
    .guid_q_i({guid_hi_q, guid_lo_q}),
    .job_valid_o(job_valid), .job_o(job), .job_full_i(job_full)
  );

  gts_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_i(job), .job_full_o(job_full),
    .valid_o, .stall_i, .kind_o, .first_sector_o, .sector_count_o,
    .entry_index_o, .verdict_o, .last_o
  );

endmodule
